// ===== hdl/mdps_pkg.sv =====
// Shared types, constants and helper functions of the next-state sampler.
`default_nettype none

package mdps_pkg;

  // Default table dimensions.
  localparam int MAX_STATES_DEF  = 16;
  localparam int MAX_ACTIONS_DEF = 4;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Field widths of the item and result ports.
  localparam int STATE_W    = 4;
  localparam int ACTION_W   = 2;
  localparam int PROB_W     = 17;
  localparam int DRAW_W     = 16;
  localparam int SCNT_W     = 5;
  localparam int ACNT_W     = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // One in unsigned Q1.16.
  localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;

  // Command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_COUNT = 4'd1;

  // Register values after reset, before clamping.
  localparam logic [SCNT_W-1:0] STATE_COUNT_RST  = 5'd16;
  localparam logic [ACNT_W-1:0] ACTION_COUNT_RST = 3'd4;

  // What the back part has to do with a queued item.
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SAMPLE,
    OP_REJECT
  } op_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_WALK
  } back_state_t;

  // Configured counts, as seen by both parts.
  typedef struct packed {
    logic [SCNT_W-1:0] state_count;
    logic [ACNT_W-1:0] action_count;
  } counts_t;

  // One classified item waiting in the queue.
  typedef struct packed {
    op_t                 op;
    logic [STATE_W-1:0]  state_index;
    logic [ACTION_W-1:0] action_index;
    logic [STATE_W-1:0]  target_state;
    logic [PROB_W-1:0]   operand;
  } qitem_t;

  function automatic logic [SCNT_W-1:0] clamp_states(logic [SCNT_W-1:0] v, int max_v);
    logic [SCNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SCNT_W'(1);
    end else if (int'(v) > max_v) begin
      r = SCNT_W'(max_v);
    end
    return r;
  endfunction

  function automatic logic [ACNT_W-1:0] clamp_actions(logic [ACNT_W-1:0] v, int max_v);
    logic [ACNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = ACNT_W'(1);
    end else if (int'(v) > max_v) begin
      r = ACNT_W'(max_v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mdps_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module mdps_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/mdps_front.sv =====
// Front part: configuration registers and classification of incoming items.
`default_nettype none

module mdps_front #(
  parameter int MAX_STATES  = mdps_pkg::MAX_STATES_DEF,
  parameter int MAX_ACTIONS = mdps_pkg::MAX_ACTIONS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [mdps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mdps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          cmd,
  input  wire logic [mdps_pkg::STATE_W-1:0]  state_index,
  input  wire logic [mdps_pkg::ACTION_W-1:0] action_index,
  input  wire logic [mdps_pkg::STATE_W-1:0]  target_state,
  input  wire logic [mdps_pkg::PROB_W-1:0]   probability,
  input  wire logic [mdps_pkg::DRAW_W-1:0]   uniform_draw,
  output mdps_pkg::qitem_t                   item,
  output mdps_pkg::counts_t                  counts
);

  import mdps_pkg::*;

  logic row_ok;
  logic tgt_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts.state_count  <= clamp_states(STATE_COUNT_RST, MAX_STATES);
      counts.action_count <= clamp_actions(ACTION_COUNT_RST, MAX_ACTIONS);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STATE_COUNT: begin
          counts.state_count <= clamp_states(cfg_data[SCNT_W-1:0], MAX_STATES);
        end
        REG_ACTION_COUNT: begin
          counts.action_count <= clamp_actions(cfg_data[ACNT_W-1:0], MAX_ACTIONS);
        end
        default: begin
        end
      endcase
    end
  end

  // Both indexes of the row must lie below the configured counts.
  assign row_ok = ({1'b0, state_index} < counts.state_count) &&
                  ({1'b0, action_index} < counts.action_count);
  assign tgt_ok = {1'b0, target_state} < counts.state_count;

  always_comb begin
    item.state_index  = state_index;
    item.action_index = action_index;
    if (cmd == CMD_WRITE) begin
      item.op           = (row_ok && tgt_ok) ? OP_WRITE : OP_REJECT;
      item.target_state = target_state;
      item.operand      = (probability > ONE_Q16) ? ONE_Q16 : probability;
    end else begin
      item.op           = row_ok ? OP_SAMPLE : OP_REJECT;
      item.target_state = '0;
      item.operand      = {1'b0, uniform_draw};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mdps_queue.sv =====
// Short first-in first-out queue of classified items.
`default_nettype none

module mdps_queue #(
  parameter int DEPTH = mdps_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  mdps_pkg::qitem_t      push_item,
  input  wire logic             pop,
  output mdps_pkg::qitem_t      head,
  output logic                  empty,
  output logic                  full
);

  import mdps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qitem_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mdps_back.sv =====
// Back part: table memory, clearing sweep, entry writes and the row walk.
`default_nettype none

module mdps_back #(
  parameter int MAX_STATES  = mdps_pkg::MAX_STATES_DEF,
  parameter int MAX_ACTIONS = mdps_pkg::MAX_ACTIONS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          empty,
  input  mdps_pkg::qitem_t                   head,
  input  mdps_pkg::counts_t                  counts,
  output logic                               pop,
  output logic                               clearing,
  output logic                               done,
  output logic [mdps_pkg::STATE_W-1:0]       chosen_state,
  output logic                               fell_through,
  output logic                               index_error
);

  import mdps_pkg::*;

  localparam int DEPTH  = MAX_STATES * MAX_ACTIONS * MAX_STATES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_STATES);
  localparam int SUM_W  = PROB_W + COL_W;

  back_state_t        state;
  back_state_t        state_next;
  logic [ADDR_W-1:0]  clr_addr;
  logic [ADDR_W-1:0]  addr;
  logic [COL_W-1:0]   col;
  logic [SUM_W-1:0]   sum;
  logic [DRAW_W-1:0]  draw;

  logic [ADDR_W-1:0]  head_addr;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [PROB_W-1:0]  ram_wdata;
  logic [PROB_W-1:0]  ram_rdata;
  logic [SUM_W-1:0]   new_sum;
  logic               hit;
  logic               last;

  mdps_ram #(
    .WIDTH(PROB_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Entry address: the row of (state, action), then the column.
  assign head_addr = ADDR_W'((int'(head.state_index) * MAX_ACTIONS +
                              int'(head.action_index)) * MAX_STATES +
                             int'(head.target_state));

  assign new_sum = sum + SUM_W'(ram_rdata);
  assign hit     = SUM_W'(draw) < new_sum;
  assign last    = int'(col) == (int'(counts.state_count) - 1);

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!empty && head.op == OP_SAMPLE) begin
          state_next = BK_WALK;
        end
      end
      BK_WALK: begin
        if (hit || last) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    clearing  = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr + 1'b1;
    ram_wdata = head.operand;
    case (state)
      BK_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      BK_IDLE: begin
        pop      = !empty;
        ram_we   = !empty && head.op == OP_WRITE;
        ram_addr = head_addr;
      end
      BK_WALK: begin
        ram_addr = addr + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (pop && head.op != OP_SAMPLE) begin
        done <= 1'b1;
      end
      if (state == BK_WALK && (hit || last)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) begin
          addr         <= head_addr;
          col          <= '0;
          sum          <= '0;
          draw         <= head.operand[DRAW_W-1:0];
          chosen_state <= '0;
          fell_through <= 1'b0;
          index_error  <= (head.op == OP_REJECT);
        end
      end
      BK_WALK: begin
        addr <= addr + 1'b1;
        if (hit) begin
          chosen_state <= STATE_W'(col);
          fell_through <= 1'b0;
          index_error  <= 1'b0;
        end else if (last) begin
          chosen_state <= '0;
          fell_through <= 1'b1;
          index_error  <= 1'b0;
        end else begin
          col <= col + 1'b1;
          sum <= new_sum;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/mdp_next_state_sampler_top.sv =====
// Top level of the next-state sampler: front part, item queue and back part.
//
//  Channel   Direction  Handshake              Payload
//  item      in         start, busy            cmd, state_index, action_index,
//                                              target_state, probability, uniform_draw
//  result    out        done (one-cycle)       chosen_state, fell_through, index_error
//  config    in         cfg_valid, cfg_ready   cfg_index, cfg_data
//
// An item is taken at a clock edge with start high and busy low. The front part
// classifies it and places it in a two-entry queue; the back part picks it up
// when it is idle. A write or a rejected item gives its result in the cycle
// after it leaves the queue; a sample walks its row through the single table
// port, one entry per cycle, summing at most state_count entries (16 by
// default), and gives its result when the walk ends.
// After reset the table is cleared by a sweep of one entry per cycle over
// MAX_STATES * MAX_ACTIONS * MAX_STATES entries (1024 by default); busy
// stays high during the sweep. Configuration writes are always taken.
// Each result appears for exactly one cycle with done high; the receiver
// cannot stall it. busy is high only during the sweep or while the queue is full.
`default_nettype none

module mdp_next_state_sampler_top #(
  parameter int MAX_STATES  = mdps_pkg::MAX_STATES_DEF,
  parameter int MAX_ACTIONS = mdps_pkg::MAX_ACTIONS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            cmd,
  input  wire logic [mdps_pkg::STATE_W-1:0]    state_index,
  input  wire logic [mdps_pkg::ACTION_W-1:0]   action_index,
  input  wire logic [mdps_pkg::STATE_W-1:0]    target_state,
  input  wire logic [mdps_pkg::PROB_W-1:0]     probability,
  input  wire logic [mdps_pkg::DRAW_W-1:0]     uniform_draw,
  output logic                                 done,
  output logic [mdps_pkg::STATE_W-1:0]         chosen_state,
  output logic                                 fell_through,
  output logic                                 index_error,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mdps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mdps_pkg::CFG_DATA_W-1:0] cfg_data
);

  import mdps_pkg::*;

  qitem_t  front_item;
  qitem_t  head;
  counts_t counts;
  logic    q_empty;
  logic    q_full;
  logic    pop;
  logic    clearing;
  logic    accept;

  // The count registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  // No item is taken during the clearing sweep or while the queue is full.
  assign busy   = clearing || q_full;
  assign accept = start && !busy;

  mdps_front #(
    .MAX_STATES (MAX_STATES),
    .MAX_ACTIONS(MAX_ACTIONS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .state_index (state_index),
    .action_index(action_index),
    .target_state(target_state),
    .probability (probability),
    .uniform_draw(uniform_draw),
    .item        (front_item),
    .counts      (counts)
  );

  mdps_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_item(front_item),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  mdps_back #(
    .MAX_STATES (MAX_STATES),
    .MAX_ACTIONS(MAX_ACTIONS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .head        (head),
    .counts      (counts),
    .pop         (pop),
    .clearing    (clearing),
    .done        (done),
    .chosen_state(chosen_state),
    .fell_through(fell_through),
    .index_error (index_error)
  );

endmodule

`default_nettype wire

// ===== hdl/mdps_checker.sv =====
// Port-level checks of the next-state sampler, bound to the top level.
`default_nettype none

module mdps_port_checks (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [3:0] chosen_state,
  input wire logic       fell_through,
  input wire logic       index_error
);

  logic [2:0] outstanding;

  // Items taken whose results have not yet appeared.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if ((start && !busy) && !done) begin
      outstanding <= outstanding + 1'b1;
    end else if (done && !(start && !busy)) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("block not busy clearing, or result shown, after reset");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> outstanding != 3'd0)
    else $error("result without a pending item");

  a_fall_through_zero: assert property (@(posedge clk) disable iff (rst)
    done && fell_through |-> chosen_state == 4'd0 && !index_error)
    else $error("fall-through result carries a state or an error");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && index_error |-> chosen_state == 4'd0 && !fell_through)
    else $error("index error result carries a state or fall-through");

endmodule

bind mdp_next_state_sampler_top mdps_port_checks u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .chosen_state(chosen_state),
  .fell_through(fell_through),
  .index_error (index_error)
);

`default_nettype wire
